@@ sv/css_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the cocktail shaker sorter.
// ----------------------------------------------------------------------------
package css_pkg;

	// Payload width of the key fields on the channels
	localparam int KEY_BITS = 32;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF     = 32;
	localparam int KEY_WIDTH_DEF = 32;

	// sort_order register codes
	localparam logic ORDER_ASC  = 1'b0;
	localparam logic ORDER_DESC = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_START,
		ST_RUN,
		ST_END,
		ST_EMIT
	} state_t;

	// Control of the shared compare/swap unit
	typedef struct packed {
		logic fwd;   // 1: forward pass, 0: backward pass
		logic desc;  // sort order, one of the ORDER_* codes
	} cmp_ctrl_t;

endpackage

@@ sv/css_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_in_if / css_out_if
// Valid/ready channels for keys in and sorted keys out.
// ----------------------------------------------------------------------------
interface css_in_if;
	import css_pkg::*;
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] key;
	logic                last_in;

	modport source (output valid, output key, output last_in, input ready);
	modport sink   (input valid, input key, input last_in, output ready);
endinterface

interface css_out_if;
	import css_pkg::*;
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] sorted_key;
	logic                last_out;
	logic                overflow;

	modport source (output valid, output sorted_key, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input sorted_key, input last_out, input overflow,
		output ready);
endinterface

@@ sv/cocktail_shaker_sorter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_top
// Collects a set of keys, sorts it with a cocktail shaker sort, streams it out.
// ----------------------------------------------------------------------------
// Keys arrive one per transfer on in_ch and are written to a
// DEPTH-entry key store; keys past DEPTH are dropped and flag overflow on every
// result of the run. The transfer with last_in set closes the set, and in_ch
// stays not ready until the sorted run has been handed to the output register.
// The sort runs n-1 alternating forward and backward passes over a shrinking
// window with a single compare/swap unit: each pass carries the bubbling key in
// a register, so each compare does one store read and one store write, and each
// pass ends with a write of the carried key to the window end. The results then
// stream out at one per cycle while out_ch does not stall them. Throughput is
// bounded by the one comparator and the single write port of the key store.
// sort_order (via cfg_we/cfg_wdata) is sampled while the sort runs and must
// only change idle.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_top #(
	parameter int DEPTH     = css_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = css_pkg::KEY_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	css_in_if.sink    in_ch,
	css_out_if.source out_ch,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	import css_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// Key store
	logic [KEY_WIDTH-1:0] mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;

	// Control state
	state_t        state_q, state_d;
	logic          order_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic [CW-1:0] passes_q;
	logic [IW-1:0] ptr_q;    // address of the read whose data arrives now
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic          fwd_q;
	logic [CW-1:0] k_q;      // next key to read in the output phase
	logic          rdv_q;    // read data holds a result waiting for out reg
	logic          rd_last_q;

	// Datapath registers
	logic [KEY_WIDTH-1:0] carry_q;
	logic [KEY_WIDTH-1:0] w_q;   // last key written by a compare step

	// Output register
	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic                out_last_q;
	logic                out_ovf_q;

	// Combinational helpers
	logic                 in_xfer;
	logic                 full;
	logic [CW-1:0]        n_next;
	logic [CW-1:0]        cnt_m1;
	logic                 at_end;
	logic                 issue;
	logic                 move;
	logic                 emit_done;
	cmp_ctrl_t            cmp_ctrl;
	logic [KEY_WIDTH-1:0] cmp_wr;
	logic [KEY_WIDTH-1:0] cmp_carry;

	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign n_next    = full ? count_q : count_q + 1'b1;
	assign cnt_m1    = count_q - 1'b1;
	assign at_end    = fwd_q ? (ptr_q == hi_q) : (ptr_q == lo_q);
	assign move      = rdv_q && (!out_valid_q || out_ch.ready);
	assign emit_done = (k_q == count_q) && !rdv_q;

	assign cmp_ctrl.fwd  = fwd_q;
	assign cmp_ctrl.desc = (order_q == ORDER_DESC);

	css_cmp_swap #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_cmp (
		.ctrl      (cmp_ctrl),
		.carry     (carry_q),
		.data      (rd_data_q),
		.wr_val    (cmp_wr),
		.nxt_carry (cmp_carry)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && in_ch.last_in) begin
					state_d = (n_next > CW'(1)) ? ST_SORT_START : ST_EMIT;
				end
			end
			ST_SORT_START: state_d = ST_RUN;
			ST_RUN: begin
				if (at_end) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				state_d = (passes_q == CW'(1)) ? ST_EMIT : ST_RUN;
			end
			ST_EMIT: begin
				if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: store ports and handshakes
	always_comb begin
		in_ch.ready = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = cmp_wr;
		issue       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// always ready here, so a valid key is a transfer
				in_ch.ready = 1'b1;
				wr_en       = in_ch.valid && !full;
				wr_addr     = count_q[IW-1:0];
				wr_data     = KEY_WIDTH'(in_ch.key);
			end
			ST_SORT_START: begin
				rd_en   = 1'b1;
				rd_addr = IW'(1);
			end
			ST_RUN: begin
				wr_en   = 1'b1;
				wr_addr = fwd_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
				rd_en   = !at_end;
				rd_addr = fwd_q ? ptr_q + 1'b1 : ptr_q - 1'b1;
			end
			ST_END: begin
				// carried key settles at the window end
				wr_en   = 1'b1;
				wr_addr = fwd_q ? hi_q : lo_q;
				wr_data = carry_q;
				rd_en   = (passes_q != CW'(1));
				rd_addr = fwd_q ? hi_q - 1'b1 - 1'b1 : lo_q + 1'b1 + 1'b1;
			end
			ST_EMIT: begin
				issue   = (k_q != count_q) && (!rdv_q || move);
				rd_en   = issue;
				rd_addr = k_q[IW-1:0];
			end
			default: ;
		endcase
	end

	// Key store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			order_q   <= ORDER_ASC;
			count_q   <= '0;
			dropped_q <= 1'b0;
			passes_q  <= '0;
			ptr_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			fwd_q     <= 1'b1;
			k_q       <= '0;
			rdv_q     <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
					k_q <= '0;
				end
				ST_SORT_START: begin
					ptr_q    <= IW'(1);
					lo_q     <= '0;
					hi_q     <= cnt_m1[IW-1:0];
					fwd_q    <= 1'b1;
					passes_q <= cnt_m1;
				end
				ST_RUN: begin
					if (!at_end) begin
						ptr_q <= fwd_q ? ptr_q + 1'b1 : ptr_q - 1'b1;
					end
				end
				ST_END: begin
					passes_q <= passes_q - 1'b1;
					fwd_q    <= !fwd_q;
					if (fwd_q) begin
						hi_q  <= hi_q - 1'b1;
						ptr_q <= hi_q - 1'b1 - 1'b1;
					end else begin
						lo_q  <= lo_q + 1'b1;
						ptr_q <= lo_q + 1'b1 + 1'b1;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						k_q       <= k_q + 1'b1;
						rdv_q     <= 1'b1;
						rd_last_q <= (k_q == cnt_m1);
					end else if (move) begin
						rdv_q <= 1'b0;
					end
					if (emit_done) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Sort datapath: carried key and last written key
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && count_q == '0) begin
			carry_q <= KEY_WIDTH'(in_ch.key);
		end else if (state_q == ST_RUN) begin
			carry_q <= cmp_carry;
			w_q     <= cmp_wr;
		end else if (state_q == ST_END) begin
			// new pass starts from the key the old pass wrote last
			carry_q <= w_q;
		end
	end

	// Output register: parts the store read from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_key_q  <= KEY_BITS'(rd_data_q);
			out_last_q <= rd_last_q;
			out_ovf_q  <= dropped_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sorted_key = out_key_q;
	assign out_ch.last_out   = out_last_q;
	assign out_ch.overflow   = out_ovf_q;

	// Checks
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("store read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("key count beyond store depth");

	a_ptr_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (ptr_q >= lo_q && ptr_q <= hi_q))
		else $error("compare pointer outside the pass window");

	a_emit_after_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && passes_q == CW'(1)) |=> (state_q == ST_EMIT && k_q == '0))
		else $error("output phase did not start after the final pass");

endmodule

@@ sv/css_cmp_swap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_cmp_swap
// Shared compare/swap unit: one unsigned compare of the carried key against
// the key read from the store, picks the key written back and the new carry.
// ----------------------------------------------------------------------------
module css_cmp_swap #(
	parameter int KEY_WIDTH = css_pkg::KEY_WIDTH_DEF
) (
	input  css_pkg::cmp_ctrl_t   ctrl,
	input  logic [KEY_WIDTH-1:0] carry,
	input  logic [KEY_WIDTH-1:0] data,
	output logic [KEY_WIDTH-1:0] wr_val,
	output logic [KEY_WIDTH-1:0] nxt_carry
);
	import css_pkg::*;

	logic                 sel_carry;
	logic [KEY_WIDTH-1:0] op_a;
	logic [KEY_WIDTH-1:0] op_b;
	logic                 swap;

	// Forward: pair is (carry, data); backward: (data, carry).
	// Out of order means first > second ascending, first < second descending.
	assign sel_carry = ctrl.fwd ^ ctrl.desc;
	assign op_a      = sel_carry ? carry : data;
	assign op_b      = sel_carry ? data : carry;
	assign swap      = op_a > op_b;

	assign wr_val    = swap ? data : carry;
	assign nxt_carry = swap ? carry : data;

endmodule

@@ bench/tb_cocktail_shaker_sorter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cocktail_shaker_sorter_top
// Self-checking bench for the cocktail shaker sorter.
// ----------------------------------------------------------------------------
// Key sets go in on in_ch, one key per transfer, closed by last_in. An internal
// model of the sorter keeps its own copy of the open set, the dropped flag and
// sort_order, and on every closing key it sorts the set with the same shaker
// passes and queues the expected sorted run. Each transfer on out_ch is checked
// field by field against the oldest queued result.
// Test order: short directed sets (extreme keys, duplicates, both orders, one
// and two keys), store overflow (including a dropped closing key), a long
// output hold-off that holds results in the block and stalls its input, then random sets.
// Both channels idle at random, with stretches of no idling.
// ----------------------------------------------------------------------------
module tb_cocktail_shaker_sorter_top;
	import css_pkg::*;

	localparam int  STORE_DEPTH = DEPTH_DEF;
	localparam int  SETTLE_CYC  = 8;      // block is idle once the run is out
	localparam int  HOLD_CYC    = 800;    // long output hold-off
	localparam int  RANDOM_KEYS = 310;    // random part length, in input keys
	localparam time RUN_LIMIT   = 5_000_000;

	// key patterns for generated sets
	localparam int KP_WIDE   = 0;
	localparam int KP_NARROW = 1;
	localparam int KP_EDGE   = 2;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef key_t key_q_t[$];

	typedef struct {
		key_t sorted_key;
		logic last_out;
		logic overflow;
	} sorted_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	css_in_if  in_ch();
	css_out_if out_ch();

	cocktail_shaker_sorter_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// model state
	key_t           open_set[$];        // keys stored for the set being built
	logic           open_set_dropped;   // a key of the open set was dropped
	logic           model_order;        // model copy of sort_order
	sorted_result_t expected_runs[$];   // sorted results still owed by the block

	// bench control
	int  mismatches;
	int  keys_sent;
	bit  tx_idle;           // sender inserts random gaps
	bit  rx_idle;           // receiver inserts random stalls
	int  rx_gap;            // stall cycles before the next output transfer
	int  rx_hold_cycles;    // long hold-off, counted down by the receiver

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit: far above the slowest legal run
	initial begin
		#RUN_LIMIT;
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sorter model
	// ------------------------------------------------------------------
	function automatic bit out_of_order(key_t earlier, key_t later);
		return (model_order == ORDER_DESC) ? (earlier < later) : (earlier > later);
	endfunction

	function automatic void compare_swap(int j);
		key_t t;
		if (out_of_order(open_set[j-1], open_set[j])) begin
			t             = open_set[j-1];
			open_set[j-1] = open_set[j];
			open_set[j]   = t;
		end
	endfunction

	// n-1 passes, alternating forward and backward, no early exit
	function automatic void shaker_sort_open_set();
		int n;
		int lo;
		int hi;
		n  = open_set.size();
		lo = 0;
		hi = n - 1;
		for (int pass = 1; pass < n; pass++) begin
			if (pass % 2 == 1) begin
				for (int j = lo + 1; j <= hi; j++)
					compare_swap(j);
				hi--;
			end else begin
				for (int j = hi; j > lo; j--)
					compare_swap(j);
				lo++;
			end
		end
	endfunction

	// Called for every accepted input transfer
	function automatic void absorb_key(key_t k, logic closing);
		sorted_result_t r;
		if (open_set.size() < STORE_DEPTH)
			open_set.push_back(k);
		else
			open_set_dropped = 1'b1;
		if (closing) begin
			shaker_sort_open_set();
			foreach (open_set[i]) begin
				r.sorted_key = open_set[i];
				r.last_out   = (i == open_set.size() - 1);
				r.overflow   = open_set_dropped;
				expected_runs.push_back(r);
			end
			open_set.delete();
			open_set_dropped = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Output side: stalls driven at the falling edge, checks at the rising
	// ------------------------------------------------------------------
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (rx_gap > 0) begin
				out_ch.ready <= 1'b0;
				rx_gap--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sorted_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_runs.size() == 0) begin
				$error("unexpected result transfer: sorted_key %h", out_ch.sorted_key);
				mismatches++;
			end else begin
				want = expected_runs.pop_front();
				if (out_ch.sorted_key !== want.sorted_key) begin
					$error("sorted_key: expected %h, actual %h",
						want.sorted_key, out_ch.sorted_key);
					mismatches++;
				end
				if (out_ch.last_out !== want.last_out) begin
					$error("last_out: expected %b, actual %b",
						want.last_out, out_ch.last_out);
					mismatches++;
				end
				if (out_ch.overflow !== want.overflow) begin
					$error("overflow: expected %b, actual %b",
						want.overflow, out_ch.overflow);
					mismatches++;
				end
			end
			rx_gap = rx_idle ? $urandom_range(0, 10) : 0;
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Offer one key and wait for its transfer; valid stays up afterwards so
	// that back-to-back keys follow without a gap.
	task automatic send_key(key_t k, logic closing);
		int gap;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.key     <= k;
		in_ch.last_in <= closing;
		do @(posedge clk); while (!in_ch.ready);
		absorb_key(k, closing);
		keys_sent++;
	endtask

	// Whole set, closed on its final key; valid drops afterwards
	task automatic send_set(key_q_t keys);
		foreach (keys[i])
			send_key(keys[i], i == keys.size() - 1);
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	function automatic key_t draw_key(int pattern);
		key_t edge_keys[5];
		edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001};
		case (pattern)
			KP_NARROW: return key_t'($urandom_range(0, 7));
			KP_EDGE:   return edge_keys[$urandom_range(0, 4)];
			default:   return key_t'($urandom);
		endcase
	endfunction

	function automatic key_q_t make_set(int n, int pattern);
		key_q_t keys;
		repeat (n) keys.push_back(draw_key(pattern));
		return keys;
	endfunction

	// Wait until every owed result is out, then let the block settle
	task automatic wait_idle();
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// sort_order is written only with the block idle
	task automatic write_order(logic order);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= order;
		@(negedge clk);
		cfg_we    <= 1'b0;
		model_order = order;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_order(ORDER_ASC);
		// extreme keys with a duplicate
		send_set('{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001});
		// one key: no passes at all
		send_set('{32'hA5A5_A5A5});
		// two keys, swapped on the only pass
		send_set('{32'hFFFF_FFFE, 32'h0000_0002});
		write_order(ORDER_DESC);
		send_set('{32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003,
			32'h0000_0010});
		// ascending input reversed
		send_set('{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004});
	endtask

	task automatic test_overflow();
		write_order(ORDER_ASC);
		// store full, closing key itself dropped
		send_set(make_set(STORE_DEPTH + 1, KP_WIDE));
		// several keys dropped before the close
		send_set(make_set(STORE_DEPTH + 5, KP_NARROW));
		write_order(ORDER_DESC);
		// exactly full: no drop, flag must have cleared
		send_set(make_set(STORE_DEPTH, KP_WIDE));
	endtask

	// Output held off while the sender keeps offering: the block takes a set,
	// sorts it, and must stall its input until the run drains.
	task automatic test_backpressure();
		wait_idle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		@(posedge clk);
		rx_hold_cycles = HOLD_CYC;
		repeat (3) send_set(make_set(12, KP_WIDE));
	endtask

	task automatic test_random();
		int first_key;
		int n;
		first_key = keys_sent;
		while (keys_sent - first_key < RANDOM_KEYS) begin
			if ($urandom_range(0, 3) == 0)
				write_order($urandom_range(0, 1) ? ORDER_DESC : ORDER_ASC);
			// mostly small sets; now and then near-full, full or overfull ones
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 4)
				: $urandom_range(1, 10);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			send_set(make_set(n, $urandom_range(KP_WIDE, KP_EDGE)));
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.key        = '0;
		in_ch.last_in    = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = ORDER_ASC;
		model_order      = ORDER_ASC;
		open_set_dropped = 1'b0;
		mismatches       = 0;
		keys_sent        = 0;
		tx_idle          = 1'b0;
		rx_idle          = 1'b0;
		rx_gap           = 0;
		rx_hold_cycles   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_overflow();
		test_backpressure();
		test_random();
		wait_idle();

		if (mismatches == 0 && expected_runs.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/css_pkg.sv
sv/css_if.sv
sv/css_cmp_swap.sv
sv/cocktail_shaker_sorter_top.sv
bench/tb_cocktail_shaker_sorter_top.sv
